// File: hw/rtl/lmm_pkg.sv
`timescale 1ns / 1ps
// Package of the 3x3 local-maximum marker: widths, register indexes and shared types.
// Depends on nothing; every other file of the block imports it.
package lmm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WCFG_BITS   = COL_BITS + 1;
  localparam int ROW_BITS    = 16;
  localparam int CFG_BITS    = 16;
  localparam int SLOTS       = 4;

  localparam logic [WCFG_BITS-1:0] WIDTH_RESET  = WCFG_BITS'(MAX_WIDTH);
  localparam logic [ROW_BITS-1:0]  HEIGHT_RESET = ROW_BITS'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // One window column, index 0 is the row two above, index 2 the newest row.
  typedef sample_t [2:0] column_t;
  // Window of three columns, index 2 is the newest column.
  typedef column_t [2:0] window_t;

  typedef struct packed {
    sample_t two_above;
    sample_t above;
  } line_word_t;

  typedef struct packed {
    logic [SLOTS-1:0]    mask;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
  } job_t;

  typedef struct packed {
    logic job_ready;
    logic busy;
  } emit_stat_t;

endpackage

// File: hw/rtl/lmm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on lmm_pkg for the payload widths.
interface lmm_sample_if;
  import lmm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface lmm_result_if;
  import lmm_pkg::*;
  logic                valid;
  logic                ready;
  logic [ROW_BITS-1:0] out_row;
  logic [COL_BITS-1:0] out_col;
  sample_t             out_value;
  logic                is_max;
  logic                run_last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output is_max, output run_last, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input is_max, input run_last, output ready);
endinterface

// File: hw/rtl/lmm_line_store.sv
`timescale 1ns / 1ps
// Line store holding the two previous rows side by side in one word per column.
// One write and one read port, read data registered. Depends on lmm_pkg.
module lmm_line_store import lmm_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [COL_BITS-1:0] waddr_i,
  input  line_word_t          wdata_i,
  input  logic                re_i,
  input  logic [COL_BITS-1:0] raddr_i,
  output line_word_t          rdata_o
);

  line_word_t mem [MAX_WIDTH];
  line_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lmm_cell.sv
`timescale 1ns / 1ps
// One column cell of the 3x3 window chain: holds three samples and passes them on
// to its older neighbour on every shift. Depends on lmm_pkg.
module lmm_cell import lmm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    shift_i,
  input  column_t col_i,
  output column_t col_o
);

  column_t col_q;
  column_t col_d;

  always_comb begin
    col_d = shift_i ? col_i : col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

// File: hw/rtl/lmm_emit.sv
`timescale 1ns / 1ps
// Result sequencer: takes the set of results due for one sample and, while the output
// is not stalled, evaluates one window element a cycle against its existing neighbours
// and drives the output register. Depends on lmm_pkg and lmm_if.
module lmm_emit import lmm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  job_t                job_i,
  input  window_t             window_i,
  output emit_stat_t          stat_o,
  lmm_result_if.source        out_if
);

  logic [SLOTS-1:0]    mask_q, mask_d;
  logic [ROW_BITS-1:0] row_q, row_d;
  logic [COL_BITS-1:0] col_q, col_d;
  logic                out_valid_q, out_valid_d;
  logic [ROW_BITS-1:0] out_row_q, out_row_d;
  logic [COL_BITS-1:0] out_col_q, out_col_d;
  sample_t             out_value_q, out_value_d;
  logic                out_max_q, out_max_d;
  logic                out_last_q, out_last_d;

  sample_t          pad [4][4];
  logic [1:0]       sel;
  logic [SLOTS-1:0] sel_oh;
  logic [SLOTS-1:0] rest;
  logic             top_pair;
  logic             up, down, left, right;
  logic [1:0]       wr, wc, ri, ci;
  logic             row_ok, col_ok;
  sample_t          centre, nb;
  logic             is_max;
  logic             fire;

  // Pick the earliest pending result and evaluate its centre element.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        pad[k][j] = '0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        pad[k][j] = window_i[j][k];
      end
    end

    if (mask_q[0]) begin
      sel = 2'd0;
    end else if (mask_q[1]) begin
      sel = 2'd1;
    end else if (mask_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    sel_oh   = SLOTS'(1) << sel;
    rest     = mask_q & ~sel_oh;
    top_pair = !sel[1];

    up    = top_pair ? (row_q > ROW_BITS'(1)) : (row_q != '0);
    down  = top_pair;
    left  = sel[0] ? (col_q != '0) : (col_q > COL_BITS'(1));
    right = !sel[0];
    wr    = top_pair ? 2'd1 : 2'd2;
    wc    = sel[0] ? 2'd2 : 2'd1;

    centre = pad[wr][wc];
    is_max = 1'b1;
    ri     = '0;
    ci     = '0;
    nb     = '0;
    row_ok = 1'b0;
    col_ok = 1'b0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        ri     = wr + 2'(dr) - 2'd1;
        ci     = wc + 2'(dc) - 2'd1;
        nb     = pad[ri][ci];
        row_ok = (dr == 0) ? up : ((dr == 2) ? down : 1'b1);
        col_ok = (dc == 0) ? left : ((dc == 2) ? right : 1'b1);
        if (!(dr == 1 && dc == 1) && row_ok && col_ok && !(centre > nb)) begin
          is_max = 1'b0;
        end
      end
    end
  end

  assign fire = (mask_q != '0) && (!out_valid_q || out_if.ready);

  always_comb begin
    mask_d = mask_q;
    row_d  = row_q;
    col_d  = col_q;
    if (load_i) begin
      mask_d = job_i.mask;
      row_d  = job_i.row;
      col_d  = job_i.col;
    end else if (fire) begin
      mask_d = rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_value_d = out_value_q;
    out_max_d   = out_max_q;
    out_last_d  = out_last_q;
    if (fire) begin
      out_valid_d = 1'b1;
      out_row_d   = top_pair ? (row_q - ROW_BITS'(1)) : row_q;
      out_col_d   = sel[0] ? col_q : (col_q - COL_BITS'(1));
      // Negating the most negative sample saturates to the largest positive one.
      if (!is_max) begin
        out_value_d = centre;
      end else if (centre == SAMPLE_MIN) begin
        out_value_d = SAMPLE_MAX;
      end else begin
        out_value_d = -centre;
      end
      out_max_d  = is_max;
      out_last_d = (rest == '0);
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_value_q <= out_value_d;
    out_max_q   <= out_max_d;
    out_last_q  <= out_last_d;
  end

  assign stat_o.busy      = (mask_q != '0);
  assign stat_o.job_ready = (mask_q == '0) || (fire && (rest == '0));

  assign out_if.valid     = out_valid_q;
  assign out_if.out_row   = out_row_q;
  assign out_if.out_col   = out_col_q;
  assign out_if.out_value = out_value_q;
  assign out_if.is_max    = out_max_q;
  assign out_if.run_last  = out_last_q;

endmodule

// File: hw/rtl/local_max_3x3_marker_top.sv
`timescale 1ns / 1ps
// Top level of the 3x3 local-maximum marker: position counters, line store,
// window cell chain and result sequencer. Depends on lmm_pkg, lmm_if and all lmm_ modules.
//
//   channel | direction | transaction carries
//   --------+-----------+-------------------------------------------------
//   in_if   | in        | sample
//   out_if  | out       | out_row, out_col, out_value, is_max, run_last
//   cfg     | in        | cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
// A sample is accepted and its line-store column read in the same cycle. It waits in
// stage B until the sequencer can take its job; then the window shifts, the job is loaded
// and the sequencer registers the first result. The sequencer issues one result per cycle
// while the output is not stalled, so a sample that causes k results holds the input until
// they are issued (one at the row interior, up to four on the last row).
// Reset clears counters, window and handshake state; the line store is not cleared.
// A stalled output holds the output register and, with a job pending, the stages behind it.
module local_max_3x3_marker_top import lmm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  lmm_sample_if.sink          in_if,
  lmm_result_if.source        out_if,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  logic [WCFG_BITS-1:0] frame_width_q, frame_width_d;
  logic [ROW_BITS-1:0]  frame_height_q, frame_height_d;
  logic [ROW_BITS-1:0]  row_count_q, row_count_d;
  logic [COL_BITS-1:0]  col_count_q, col_count_d;

  logic                 valid_b_q, valid_b_d;
  logic [ROW_BITS-1:0]  r_b_q;
  logic [COL_BITS-1:0]  c_b_q;
  logic                 lrow_b_q, lcol_b_q;
  sample_t              s_b_q;
  logic                 byp_hit_q, byp_hit_d;
  line_word_t           byp_data_q;

  logic [WCFG_BITS-1:0] width_eff;
  logic [ROW_BITS-1:0]  height_eff;
  logic                 last_col, last_row;
  logic                 accept;
  logic                 b_adv;
  line_word_t           rd_word, above_word, new_word;
  sample_t              a1, a2;
  column_t              new_col;
  column_t              cols [3];
  window_t              window;
  job_t                 job;
  emit_stat_t           emit_stat;

  // Configuration registers.
  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_d  = cfg_data_i[WCFG_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height_d = cfg_data_i[ROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = WCFG_BITS'(1);
    end else if (frame_width_q > WCFG_BITS'(MAX_WIDTH)) begin
      width_eff = WCFG_BITS'(MAX_WIDTH);
    end else begin
      width_eff = frame_width_q;
    end
    height_eff = (frame_height_q == '0) ? ROW_BITS'(1) : frame_height_q;
    last_col   = ({1'b0, col_count_q} + WCFG_BITS'(1)) >= width_eff;
    last_row   = ({1'b0, row_count_q} + (ROW_BITS+1)'(1)) >= {1'b0, height_eff};
  end

  assign b_adv       = valid_b_q && emit_stat.job_ready;
  assign in_if.ready = !valid_b_q || b_adv;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    row_count_d = row_count_q;
    col_count_d = col_count_q;
    if (accept) begin
      if (last_col) begin
        col_count_d = '0;
        row_count_d = last_row ? '0 : (row_count_q + ROW_BITS'(1));
      end else begin
        col_count_d = col_count_q + COL_BITS'(1);
      end
    end
  end

  always_comb begin
    valid_b_d = valid_b_q;
    if (accept) begin
      valid_b_d = 1'b1;
    end else if (b_adv) begin
      valid_b_d = 1'b0;
    end
    // A read in the same cycle as a write to the same column sees the old word,
    // so the word being written is kept and used in its place.
    byp_hit_d = b_adv && (c_b_q == col_count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
      row_count_q    <= '0;
      col_count_q    <= '0;
      valid_b_q      <= 1'b0;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
      row_count_q    <= row_count_d;
      col_count_q    <= col_count_d;
      valid_b_q      <= valid_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_b_q      <= row_count_q;
      c_b_q      <= col_count_q;
      lrow_b_q   <= last_row;
      lcol_b_q   <= last_col;
      s_b_q      <= in_if.sample;
      byp_hit_q  <= byp_hit_d;
      byp_data_q <= new_word;
    end
  end

  lmm_line_store u_line_store (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (c_b_q),
    .wdata_i (new_word),
    .re_i    (accept),
    .raddr_i (col_count_q),
    .rdata_o (rd_word)
  );

  always_comb begin
    above_word         = byp_hit_q ? byp_data_q : rd_word;
    a1                 = (r_b_q != '0) ? above_word.above : '0;
    a2                 = (r_b_q > ROW_BITS'(1)) ? above_word.two_above : '0;
    new_word.two_above = a1;
    new_word.above     = s_b_q;
    new_col[0]         = a2;
    new_col[1]         = a1;
    new_col[2]         = s_b_q;
  end

  // Window chain: the newest column enters cell 2 and moves one cell older per shift.
  for (genvar j = 0; j < 3; j++) begin : g_cell
    column_t feed;
    if (j == 2) begin : g_head
      assign feed = new_col;
    end else begin : g_link
      assign feed = cols[j+1];
    end
    lmm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (b_adv),
      .col_i   (feed),
      .col_o   (cols[j])
    );
    assign window[j] = cols[j];
  end

  always_comb begin
    job.row     = r_b_q;
    job.col     = c_b_q;
    job.mask[0] = (r_b_q != '0) && (c_b_q != '0);
    job.mask[1] = (r_b_q != '0) && lcol_b_q;
    job.mask[2] = lrow_b_q && (c_b_q != '0);
    job.mask[3] = lrow_b_q && lcol_b_q;
  end

  lmm_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (b_adv),
    .job_i    (job),
    .window_i (window),
    .stat_o   (emit_stat),
    .out_if   (out_if)
  );

`ifndef SYNTHESIS
  a_hold_stage_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_b_q && !b_adv |=> valid_b_q && $stable(s_b_q) && $stable(c_b_q))
    else $error("stage B item changed while it was held");

  a_job_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv && (job.mask != '0) |=> emit_stat.busy)
    else $error("a job with pending results was not taken by the sequencer");

  a_out_from_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(emit_stat.busy))
    else $error("a result appeared without a pending job");
`endif

endmodule
